/* hdl/bbf_pkg.sv */
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared constants, request codes and controller/datapath interface types for
// the bounded byte fifo.
// ----------------------------------------------------------------------------
package bbf_pkg;

  // build defaults
  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 64;

  // field widths
  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 11;
  localparam int TOT_W  = 32;

  // stream word widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 104;

  localparam logic [STAT_W-1:0] CAP_RESET = 11'd1024;

  // request codes
  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_END   = 3'd4;

  typedef struct packed {
    logic capture;
    logic execute;
    logic send_status;
    logic burst;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic out_free;
    logic burst_end;
  } sts_t;

endpackage

/* hdl/bbf_ctrl.sv */
// ----------------------------------------------------------------------------
// bbf_ctrl
// Request sequencer: accept a request, apply it, then send a status word or
// run the byte burst of a peek or read.
// ----------------------------------------------------------------------------
module bbf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bbf_pkg::sts_t sts,
  output bbf_pkg::cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_RESP  = 2'd2;
  localparam logic [1:0] ST_BURST = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = sts.emit ? ST_BURST : ST_RESP;
      end
      ST_RESP: begin
        cmd.send_status = 1'b1;
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_BURST: begin
        cmd.burst = 1'b1;
        if (sts.burst_end) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/bbf_datapath.sv */
// ----------------------------------------------------------------------------
// bbf_datapath
// Byte store, pointers, fill level, totals, burst counters and the output
// word register.
// ----------------------------------------------------------------------------
module bbf_datapath #(
  parameter int DEPTH     = bbf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = bbf_pkg::MAX_BURST_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cap_we,
  input  logic [bbf_pkg::STAT_W-1:0]  cap_wdata,
  input  logic [bbf_pkg::OP_W-1:0]    in_op,
  input  logic [bbf_pkg::BYTE_W-1:0]  in_data,
  input  logic [bbf_pkg::LEN_W-1:0]   in_len,
  input  bbf_pkg::cmd_t               cmd,
  output bbf_pkg::sts_t               sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bbf_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_byte_valid,
  output logic                        out_last,
  output logic                        out_accepted,
  output logic [bbf_pkg::STAT_W-1:0]  out_fill,
  output logic [bbf_pkg::STAT_W-1:0]  out_free_space,
  output logic                        out_eof,
  output logic                        out_ended,
  output logic [bbf_pkg::TOT_W-1:0]   out_total_written,
  output logic [bbf_pkg::TOT_W-1:0]   out_total_read
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int N_W   = $clog2(MAX_BURST + 1);

  logic [bbf_pkg::BYTE_W-1:0] mem [DEPTH];

  // request held for execution
  logic [bbf_pkg::OP_W-1:0]   op_q;
  logic [bbf_pkg::BYTE_W-1:0] data_q;
  logic [bbf_pkg::LEN_W-1:0]  len_q;

  // fifo state
  logic [PTR_W-1:0]           head;
  logic [CNT_W-1:0]           fill;
  logic                       done;
  logic [bbf_pkg::TOT_W-1:0]  wtot;
  logic [bbf_pkg::TOT_W-1:0]  rtot;
  logic [bbf_pkg::STAT_W-1:0] cap;

  // burst
  logic                       acc_q;
  logic [N_W-1:0]             n_q;
  logic [N_W-1:0]             issue_cnt;
  logic [N_W-1:0]             load_cnt;
  logic [PTR_W-1:0]           rd_ptr;
  logic                       rd_pending;
  logic [bbf_pkg::BYTE_W-1:0] rd_data;

  logic [CNT_W-1:0]           eff_cap;
  logic [CNT_W-1:0]           free_calc;
  logic [bbf_pkg::LEN_W-1:0]  len_clamp;
  logic [N_W-1:0]             n_calc;
  logic                       is_emit_op;
  logic                       wr_ok;
  logic [PTR_W:0]             wr_sum;
  logic [PTR_W-1:0]           wr_addr;
  logic [PTR_W:0]             hd_sum;
  logic [PTR_W-1:0]           hd_next;
  logic                       out_free;
  logic                       load_byte;
  logic                       load_status;
  logic                       issue;
  logic                       byte_last;

  always_comb begin
    eff_cap = (32'(cap) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap);
    free_calc = (eff_cap > fill) ? CNT_W'(eff_cap - fill) : '0;

    len_clamp = (32'(len_q) > 32'(MAX_BURST)) ? bbf_pkg::LEN_W'(MAX_BURST) : len_q;
    n_calc = (32'(len_clamp) < 32'(fill)) ? N_W'(len_clamp) : N_W'(fill);

    is_emit_op = (op_q == bbf_pkg::OP_PEEK) || (op_q == bbf_pkg::OP_READ);
    wr_ok = (op_q == bbf_pkg::OP_WRITE) && (fill < eff_cap);

    // both sums stay below twice the depth, so one subtract wraps them
    wr_sum  = {1'b0, head} + (PTR_W + 1)'(fill);
    wr_addr = (wr_sum >= (PTR_W + 1)'(DEPTH)) ?
              PTR_W'(wr_sum - (PTR_W + 1)'(DEPTH)) : wr_sum[PTR_W-1:0];
    hd_sum  = {1'b0, head} + (PTR_W + 1)'(n_calc);
    hd_next = (hd_sum >= (PTR_W + 1)'(DEPTH)) ?
              PTR_W'(hd_sum - (PTR_W + 1)'(DEPTH)) : hd_sum[PTR_W-1:0];

    out_free    = !out_valid || out_ready;
    load_status = cmd.send_status && out_free;
    load_byte   = cmd.burst && rd_pending && out_free;
    // keep one read in flight ahead of the output word
    issue       = cmd.burst && (issue_cnt < n_q) && (!rd_pending || load_byte);
    byte_last   = ((N_W + 1)'(load_cnt) + (N_W + 1)'(1)) == (N_W + 1)'(n_q);

    sts.emit      = is_emit_op && (n_calc != '0);
    sts.out_free  = out_free;
    sts.burst_end = load_byte && byte_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill       <= '0;
      done       <= 1'b0;
      wtot       <= '0;
      rtot       <= '0;
      cap        <= bbf_pkg::CAP_RESET;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cap_we) begin
        cap <= cap_wdata;
      end
      if (cmd.execute) begin
        unique case (op_q) inside
          bbf_pkg::OP_WRITE: begin
            if (wr_ok) begin
              fill <= fill + CNT_W'(1);
              wtot <= wtot + 32'd1;
            end
          end
          bbf_pkg::OP_POP, bbf_pkg::OP_READ: begin
            head <= hd_next;
            fill <= fill - CNT_W'(n_calc);
            rtot <= rtot + 32'(n_calc);
          end
          bbf_pkg::OP_END: begin
            done <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (issue) begin
        rd_pending <= 1'b1;
      end else if (load_byte) begin
        rd_pending <= 1'b0;
      end
      if (load_status || load_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= in_op;
      data_q <= in_data;
      len_q  <= in_len;
    end
    if (cmd.execute) begin
      acc_q     <= wr_ok;
      n_q       <= n_calc;
      rd_ptr    <= head;
      issue_cnt <= '0;
      load_cnt  <= '0;
    end
    if (issue) begin
      issue_cnt <= issue_cnt + N_W'(1);
      rd_ptr    <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
    if (load_byte) begin
      load_cnt <= load_cnt + N_W'(1);
    end
    if (load_status || load_byte) begin
      out_byte          <= load_byte ? rd_data : '0;
      out_byte_valid    <= load_byte;
      out_last          <= load_byte ? byte_last : 1'b1;
      out_accepted      <= load_byte ? 1'b0 : acc_q;
      out_fill          <= bbf_pkg::STAT_W'(fill);
      out_free_space    <= bbf_pkg::STAT_W'(free_calc);
      out_eof           <= (fill == '0) && done;
      out_ended         <= done;
      out_total_written <= wtot;
      out_total_read    <= rtot;
    end
  end

  // byte store
  always_ff @(posedge clk) begin
    if (cmd.execute && wr_ok) begin
      mem[wr_addr] <= data_q;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_ptr];
    end
  end

endmodule

/* hdl/bounded_byte_fifo.sv */
// ----------------------------------------------------------------------------
// bounded_byte_fifo
// Byte fifo with a programmable capacity, driven by write, peek, pop, read
// and end-of-input requests on a stream port.
// ----------------------------------------------------------------------------
// each request is accepted in the idle state and applied in the execute state;
// a write, pop, end of input, unknown request or peek/read that returns
// nothing then sends its single status word once the output register is
// free. a peek or read of n bytes streams one byte per cycle while the output
// is not stalled, after a registered read of the byte store. the output word
// register lets a new request be accepted while the last word waits to be
// taken. the store is not cleared after reset.
module bounded_byte_fifo #(
  parameter int DEPTH     = bbf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = bbf_pkg::MAX_BURST_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [bbf_pkg::STAT_W-1:0]     cfg_wr_data,   // capacity_bytes
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bbf_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // data_byte, req_len
  input  logic [bbf_pkg::OP_W-1:0]       s_axis_tuser,  // op
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_byte, accepted, fill_level, free_space, at_eof, ended_flag,
  // total_written, total_read
  output logic [bbf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                           m_axis_tuser,  // byte_valid
  output logic                           m_axis_tlast
);

  bbf_pkg::cmd_t              cmd;
  bbf_pkg::sts_t              sts;
  logic [bbf_pkg::BYTE_W-1:0] out_byte;
  logic                       out_accepted;
  logic [bbf_pkg::STAT_W-1:0] out_fill;
  logic [bbf_pkg::STAT_W-1:0] out_free_space;
  logic                       out_eof;
  logic                       out_ended;
  logic [bbf_pkg::TOT_W-1:0]  out_total_written;
  logic [bbf_pkg::TOT_W-1:0]  out_total_read;

  bbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bbf_datapath #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cap_we            (cfg_wr_en),
    .cap_wdata         (cfg_wr_data),
    .in_op             (s_axis_tuser),
    .in_data           (s_axis_tdata[7:0]),
    .in_len            (s_axis_tdata[14:8]),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (m_axis_tvalid),
    .out_ready         (m_axis_tready),
    .out_byte          (out_byte),
    .out_byte_valid    (m_axis_tuser),
    .out_last          (m_axis_tlast),
    .out_accepted      (out_accepted),
    .out_fill          (out_fill),
    .out_free_space    (out_free_space),
    .out_eof           (out_eof),
    .out_ended         (out_ended),
    .out_total_written (out_total_written),
    .out_total_read    (out_total_read)
  );

  assign m_axis_tdata = {7'd0, out_total_read, out_total_written, out_ended, out_eof,
                         out_free_space, out_fill, out_accepted, out_byte};

  // a status word always closes its request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("status word without last");

  // a stored write is reported only on a status word
  a_accept_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[8] |-> !m_axis_tuser && m_axis_tlast)
    else $error("accepted flag on a byte word");

  // a request is applied in the cycle after it is taken
  a_exec_follows: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> cmd.execute && !s_axis_tready)
    else $error("request not applied after accept");

  // a burst finishes only with a free output register
  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    sts.burst_end |-> cmd.burst && sts.out_free)
    else $error("burst ended without loading output");

endmodule
